/* rtl/sps_pkg.sv */
package sps_pkg;

  typedef struct packed {
    logic [7:0] profile_idc;
    logic [7:0] level_idc;
    logic [1:0] chroma_format;
    logic [3:0] luma_depth;
    logic [3:0] chroma_depth;
    logic [4:0] reference_frames;
    logic       is_interlaced;
    logic       aspect_present;
    logic signed [1:0] video_range;
    logic [7:0] colour_primaries;
    logic [7:0] transfer_characteristics;
    logic [7:0] matrix_coefficients;
  } sps_fields_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       final_byte;
  } sps_beat_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0] P_PROFILE = 6'd0, P_CONSTRAINT = 6'd1, P_LEVEL = 6'd2,
    P_SPS_ID = 6'd3, P_CHROMA = 6'd4, P_SEP_PLANE = 6'd5, P_LUMA_DEPTH = 6'd6,
    P_CHROMA_DEPTH = 6'd7, P_BYPASS = 6'd8, P_SCALING_FLAG = 6'd9,
    P_LIST_FLAG = 6'd10, P_LIST_DELTA = 6'd11, P_LOG2_FRAME = 6'd12,
    P_POC_TYPE = 6'd13, P_POC_LSB = 6'd14, P_DELTA_ZERO = 6'd15,
    P_OFF_NONREF = 6'd16, P_OFF_TB = 6'd17, P_CYCLE_LEN = 6'd18,
    P_CYCLE_OFF = 6'd19, P_REF_FRAMES = 6'd20, P_GAPS = 6'd21, P_MB_W = 6'd22,
    P_MB_H = 6'd23, P_FRAME_MBS = 6'd24, P_MBAFF = 6'd25, P_DIRECT = 6'd26,
    P_CROP_FLAG = 6'd27, P_CROP = 6'd28, P_VUI_FLAG = 6'd29, P_AR_FLAG = 6'd30,
    P_AR_IDC = 6'd31, P_SAR = 6'd32, P_OVERSCAN = 6'd33,
    P_OVERSCAN_APPR = 6'd34, P_SIG_TYPE = 6'd35, P_VIDEO_FORMAT = 6'd36,
    P_FULL_RANGE = 6'd37, P_COLOUR_FLAG = 6'd38, P_PRIMARIES = 6'd39,
    P_TRC = 6'd40, P_MATRIX = 6'd41, P_DONE = 6'd42;

  localparam logic [7:0] HIGH_PROFILE = 8'd100;
  localparam logic [7:0] AR_EXTENDED = 8'd255;

  // fixed read width; 0 selects an Exp-Golomb read
  function automatic logic [5:0] elem_width(input logic [5:0] pos);
    case (pos)
      P_PROFILE, P_CONSTRAINT, P_LEVEL, P_AR_IDC, P_PRIMARIES, P_TRC,
      P_MATRIX: elem_width = 6'd8;
      P_SAR: elem_width = 6'd32;
      P_VIDEO_FORMAT: elem_width = 6'd3;
      P_SEP_PLANE, P_BYPASS, P_SCALING_FLAG, P_LIST_FLAG, P_DELTA_ZERO,
      P_GAPS, P_FRAME_MBS, P_MBAFF, P_DIRECT, P_CROP_FLAG, P_VUI_FLAG,
      P_AR_FLAG, P_OVERSCAN, P_OVERSCAN_APPR, P_SIG_TYPE, P_FULL_RANGE,
      P_COLOUR_FLAG: elem_width = 6'd1;
      default: elem_width = 6'd0;
    endcase
  endfunction

  function automatic sps_fields_t default_fields();
    sps_fields_t f;
    f = '0;
    f.chroma_format = 2'd1;
    f.luma_depth = 4'd8;
    f.chroma_depth = 4'd8;
    f.video_range = -2'sd1;
    f.colour_primaries = 8'd2;
    f.transfer_characteristics = 8'd2;
    f.matrix_coefficients = 8'd2;
    return f;
  endfunction

endpackage

/* rtl/sps_stream_if.sv */
interface sps_stream_if #(parameter int W = 9);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/h264_sps_header_parser_core.sv */
// Timing: a byte's 8 bits are walked one per cycle after it leaves the queue, but the
// last bit of a final byte waits while the previous result is not yet accepted;
// the result is registered as that bit is walked, behind any byte queued ahead.
// The queue takes bytes while one is walked; the next is popped on the last bit.
// Reset (rst, synchronous): queue empty, parse at the profile element with default fields.
module h264_sps_header_parser_core #(
  parameter int MAX_GOLOMB_ZEROS = 31
) (
  input logic clk,
  input logic rst,
  sps_stream_if.sink   in_ch,
  sps_stream_if.source out_ch
);
  sps_pkg::sps_beat_t   in_beat, q_beat;
  sps_pkg::sps_fields_t res;
  logic q_valid, q_pop;

  assign in_beat.payload_byte = in_ch.data[8:1];
  assign in_beat.final_byte = in_ch.data[0];

  sps_front u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_beat,
    .q_valid, .q_pop, .q_beat
  );

  sps_back #(.MAX_GOLOMB_ZEROS(MAX_GOLOMB_ZEROS)) u_back (
    .clk, .rst,
    .q_valid, .q_pop, .q_beat,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_fields(res)
  );

  assign out_ch.data = res;

`ifndef SYNTH
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("result dropped");
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (res.luma_depth >= 4'd8 && res.luma_depth <= 4'd14))
    else $error("luma depth out of range");
`endif
endmodule

/* rtl/sps_front.sv */
// Input side: two-entry byte queue that decouples intake from the bit walker
module sps_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sps_pkg::sps_beat_t in_beat,
  output logic               q_valid,
  input  logic               q_pop,
  output sps_pkg::sps_beat_t q_beat
);
  sps_pkg::sps_beat_t slots [sps_pkg::QUEUE_DEPTH];
  logic wp, rp;
  logic [1:0] count;
  logic push;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign q_beat = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= in_beat;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

/* rtl/sps_back.sv */
// Bit walker: one RBSP bit per cycle through the SPS syntax while a byte is held, except while a finished result waits
module sps_back #(
  parameter int MAX_GOLOMB_ZEROS = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  sps_pkg::sps_beat_t   q_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sps_pkg::sps_fields_t out_fields
);
  localparam logic [4:0] MAXZ = 5'(MAX_GOLOMB_ZEROS);

  logic [5:0]  pos;
  logic [4:0]  zeros;
  logic [31:0] acc;
  logic [5:0]  taken;
  logic        suffix;
  logic        is444;
  logic [3:0]  list_num;
  logic [6:0]  entry;
  logic [7:0]  last_val;
  logic [31:0] loop_rem;
  sps_pkg::sps_fields_t cap;
  sps_pkg::sps_fields_t fin_fields;

  logic        busy;
  logic [2:0]  bit_idx;
  logic        fin;
  logic [7:0]  byte_r;

  logic        b;
  logic        step;
  logic        done_elem;
  logic [31:0] val;
  logic [31:0] acc_sh;
  logic [5:0]  w;
  logic [5:0]  nxt;
  logic [7:0]  sv;
  logic [4:0]  l_next;
  logic        list_end;

  // byte register: take a new byte when idle or when the last bit of the current one is used
  logic last_bit;
  assign last_bit = busy && (bit_idx == 3'd7);
  assign q_pop = q_valid && (!busy || (last_bit && (!fin || !out_valid)))
                 && !(fin && last_bit && out_valid);
  assign step = busy && !(last_bit && fin && out_valid);
  assign b = byte_r[3'd7 - bit_idx];
  assign w = sps_pkg::elem_width(pos);
  assign acc_sh = {acc[30:0], b};

  // element completion and value
  always_comb begin
    done_elem = 1'b0;
    val = acc_sh;
    if (pos != sps_pkg::P_DONE) begin
      if (w != 6'd0) begin
        done_elem = (taken + 6'd1 >= w);
      end else if (!suffix) begin
        done_elem = b && (zeros == 5'd0);
        val = '0;
      end else begin
        done_elem = ({1'b0, taken} + 7'd1 >= {2'b0, zeros});
        val = ((32'd1 << zeros) - 32'd1) + acc_sh;
      end
    end
  end

  assign sv = val[0] ? (last_val + val[8:1] + 8'd1) : (last_val - val[8:1]);
  assign l_next = {1'b0, list_num} + 5'd1;
  assign list_end = (l_next >= (is444 ? 5'd12 : 5'd8));

  // captured fields including an element that ends on the current bit
  always_comb begin
    fin_fields = cap;
    if (done_elem) begin
      case (pos)
        sps_pkg::P_PROFILE: fin_fields.profile_idc = val[7:0];
        sps_pkg::P_LEVEL: fin_fields.level_idc = val[7:0];
        sps_pkg::P_CHROMA: fin_fields.chroma_format = (val > 32'd3) ? 2'd3 : val[1:0];
        sps_pkg::P_LUMA_DEPTH:
          fin_fields.luma_depth = (val > 32'd6) ? 4'd14 : val[3:0] + 4'd8;
        sps_pkg::P_CHROMA_DEPTH:
          fin_fields.chroma_depth = (val > 32'd6) ? 4'd14 : val[3:0] + 4'd8;
        sps_pkg::P_REF_FRAMES:
          fin_fields.reference_frames = (val > 32'd16) ? 5'd16 : val[4:0];
        sps_pkg::P_FRAME_MBS: fin_fields.is_interlaced = ~val[0];
        sps_pkg::P_AR_FLAG: fin_fields.aspect_present = val[0];
        sps_pkg::P_FULL_RANGE: fin_fields.video_range = {1'b0, val[0]};
        sps_pkg::P_PRIMARIES: fin_fields.colour_primaries = val[7:0];
        sps_pkg::P_TRC: fin_fields.transfer_characteristics = val[7:0];
        sps_pkg::P_MATRIX: fin_fields.matrix_coefficients = val[7:0];
        default: ;
      endcase
    end
  end

  // next syntax position
  always_comb begin
    nxt = sps_pkg::P_DONE;
    case (pos)
      sps_pkg::P_PROFILE: nxt = sps_pkg::P_CONSTRAINT;
      sps_pkg::P_CONSTRAINT: nxt = sps_pkg::P_LEVEL;
      sps_pkg::P_LEVEL: nxt = sps_pkg::P_SPS_ID;
      sps_pkg::P_SPS_ID: nxt = (cap.profile_idc >= sps_pkg::HIGH_PROFILE)
                               ? sps_pkg::P_CHROMA : sps_pkg::P_LOG2_FRAME;
      sps_pkg::P_CHROMA: nxt = (val == 32'd3) ? sps_pkg::P_SEP_PLANE
                                              : sps_pkg::P_LUMA_DEPTH;
      sps_pkg::P_SEP_PLANE: nxt = sps_pkg::P_LUMA_DEPTH;
      sps_pkg::P_LUMA_DEPTH: nxt = sps_pkg::P_CHROMA_DEPTH;
      sps_pkg::P_CHROMA_DEPTH: nxt = sps_pkg::P_BYPASS;
      sps_pkg::P_BYPASS: nxt = sps_pkg::P_SCALING_FLAG;
      sps_pkg::P_SCALING_FLAG: nxt = val[0] ? sps_pkg::P_LIST_FLAG
                                            : sps_pkg::P_LOG2_FRAME;
      sps_pkg::P_LIST_FLAG:
        nxt = val[0] ? sps_pkg::P_LIST_DELTA
              : (list_end ? sps_pkg::P_LOG2_FRAME : sps_pkg::P_LIST_FLAG);
      sps_pkg::P_LIST_DELTA: begin
        if (sv == 8'd0 || {1'b0, entry} + 8'd1 >= (list_num < 4'd6 ? 8'd16 : 8'd64))
          nxt = list_end ? sps_pkg::P_LOG2_FRAME : sps_pkg::P_LIST_FLAG;
        else
          nxt = sps_pkg::P_LIST_DELTA;
      end
      sps_pkg::P_LOG2_FRAME: nxt = sps_pkg::P_POC_TYPE;
      sps_pkg::P_POC_TYPE: nxt = (val == 32'd0) ? sps_pkg::P_POC_LSB
                        : ((val == 32'd1) ? sps_pkg::P_DELTA_ZERO : sps_pkg::P_REF_FRAMES);
      sps_pkg::P_POC_LSB: nxt = sps_pkg::P_REF_FRAMES;
      sps_pkg::P_DELTA_ZERO: nxt = sps_pkg::P_OFF_NONREF;
      sps_pkg::P_OFF_NONREF: nxt = sps_pkg::P_OFF_TB;
      sps_pkg::P_OFF_TB: nxt = sps_pkg::P_CYCLE_LEN;
      sps_pkg::P_CYCLE_LEN: nxt = (val == 32'd0) ? sps_pkg::P_REF_FRAMES
                                                 : sps_pkg::P_CYCLE_OFF;
      sps_pkg::P_CYCLE_OFF: nxt = (loop_rem == 32'd1) ? sps_pkg::P_REF_FRAMES
                                                      : sps_pkg::P_CYCLE_OFF;
      sps_pkg::P_REF_FRAMES: nxt = sps_pkg::P_GAPS;
      sps_pkg::P_GAPS: nxt = sps_pkg::P_MB_W;
      sps_pkg::P_MB_W: nxt = sps_pkg::P_MB_H;
      sps_pkg::P_MB_H: nxt = sps_pkg::P_FRAME_MBS;
      sps_pkg::P_FRAME_MBS: nxt = val[0] ? sps_pkg::P_DIRECT : sps_pkg::P_MBAFF;
      sps_pkg::P_MBAFF: nxt = sps_pkg::P_DIRECT;
      sps_pkg::P_DIRECT: nxt = sps_pkg::P_CROP_FLAG;
      sps_pkg::P_CROP_FLAG: nxt = val[0] ? sps_pkg::P_CROP : sps_pkg::P_VUI_FLAG;
      sps_pkg::P_CROP: nxt = (loop_rem == 32'd1) ? sps_pkg::P_VUI_FLAG
                                                 : sps_pkg::P_CROP;
      sps_pkg::P_VUI_FLAG: nxt = val[0] ? sps_pkg::P_AR_FLAG : sps_pkg::P_DONE;
      sps_pkg::P_AR_FLAG: nxt = val[0] ? sps_pkg::P_AR_IDC : sps_pkg::P_OVERSCAN;
      sps_pkg::P_AR_IDC: nxt = (val[7:0] == sps_pkg::AR_EXTENDED)
                               ? sps_pkg::P_SAR : sps_pkg::P_OVERSCAN;
      sps_pkg::P_SAR: nxt = sps_pkg::P_OVERSCAN;
      sps_pkg::P_OVERSCAN: nxt = val[0] ? sps_pkg::P_OVERSCAN_APPR
                                        : sps_pkg::P_SIG_TYPE;
      sps_pkg::P_OVERSCAN_APPR: nxt = sps_pkg::P_SIG_TYPE;
      sps_pkg::P_SIG_TYPE: nxt = val[0] ? sps_pkg::P_VIDEO_FORMAT : sps_pkg::P_DONE;
      sps_pkg::P_VIDEO_FORMAT: nxt = sps_pkg::P_FULL_RANGE;
      sps_pkg::P_FULL_RANGE: nxt = sps_pkg::P_COLOUR_FLAG;
      sps_pkg::P_COLOUR_FLAG: nxt = val[0] ? sps_pkg::P_PRIMARIES : sps_pkg::P_DONE;
      sps_pkg::P_PRIMARIES: nxt = sps_pkg::P_TRC;
      sps_pkg::P_TRC: nxt = sps_pkg::P_MATRIX;
      default: nxt = sps_pkg::P_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) byte_r <= q_beat.payload_byte;
  end

  // walker state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bit_idx <= 3'd0;
      fin <= 1'b0;
      out_valid <= 1'b0;
      out_fields <= sps_pkg::default_fields();
      cap <= sps_pkg::default_fields();
      pos <= sps_pkg::P_PROFILE;
      zeros <= '0;
      acc <= '0;
      taken <= '0;
      suffix <= 1'b0;
      is444 <= 1'b0;
      list_num <= '0;
      entry <= '0;
      last_val <= 8'd8;
      loop_rem <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (q_pop) begin
        busy <= 1'b1;
        bit_idx <= 3'd0;
        fin <= q_beat.final_byte;
      end else if (step) begin
        bit_idx <= bit_idx + 3'd1;
        if (last_bit) busy <= 1'b0;
      end
      if (step && last_bit && fin) begin
        // emit and restart; an element ending on this bit still counts
        out_valid <= 1'b1;
        out_fields <= fin_fields;
        cap <= sps_pkg::default_fields();
        pos <= sps_pkg::P_PROFILE;
        zeros <= '0;
        acc <= '0;
        taken <= '0;
        suffix <= 1'b0;
        is444 <= 1'b0;
        list_num <= '0;
        entry <= '0;
        last_val <= 8'd8;
        loop_rem <= '0;
      end else if (step && pos != sps_pkg::P_DONE) begin
        if (done_elem) begin
          pos <= nxt;
          acc <= '0;
          taken <= '0;
          zeros <= '0;
          suffix <= 1'b0;
          case (pos)
            sps_pkg::P_PROFILE: cap.profile_idc <= val[7:0];
            sps_pkg::P_LEVEL: cap.level_idc <= val[7:0];
            sps_pkg::P_CHROMA: begin
              is444 <= (val == 32'd3);
              cap.chroma_format <= (val > 32'd3) ? 2'd3 : val[1:0];
            end
            sps_pkg::P_LUMA_DEPTH: cap.luma_depth <= (val > 32'd6) ? 4'd14 : val[3:0] + 4'd8;
            sps_pkg::P_CHROMA_DEPTH: cap.chroma_depth <= (val > 32'd6) ? 4'd14 : val[3:0] + 4'd8;
            sps_pkg::P_SCALING_FLAG: list_num <= '0;
            sps_pkg::P_LIST_FLAG: begin
              if (val[0]) begin
                last_val <= 8'd8;
                entry <= '0;
              end else begin
                list_num <= l_next[3:0];
              end
            end
            sps_pkg::P_LIST_DELTA: begin
              if (sv == 8'd0 || {1'b0, entry} + 8'd1 >= (list_num < 4'd6 ? 8'd16 : 8'd64))
                list_num <= l_next[3:0];
              if (sv != 8'd0) begin
                last_val <= sv;
                entry <= entry + 7'd1;
              end
            end
            sps_pkg::P_CYCLE_LEN: loop_rem <= val;
            sps_pkg::P_CYCLE_OFF, sps_pkg::P_CROP: loop_rem <= loop_rem - 32'd1;
            sps_pkg::P_CROP_FLAG: loop_rem <= 32'd4;
            sps_pkg::P_REF_FRAMES: cap.reference_frames <= (val > 32'd16) ? 5'd16 : val[4:0];
            sps_pkg::P_FRAME_MBS: cap.is_interlaced <= ~val[0];
            sps_pkg::P_AR_FLAG: cap.aspect_present <= val[0];
            sps_pkg::P_FULL_RANGE: cap.video_range <= {1'b0, val[0]};
            sps_pkg::P_PRIMARIES: cap.colour_primaries <= val[7:0];
            sps_pkg::P_TRC: cap.transfer_characteristics <= val[7:0];
            sps_pkg::P_MATRIX: cap.matrix_coefficients <= val[7:0];
            default: ;
          endcase
        end else if (w != 6'd0) begin
          acc <= acc_sh;
          taken <= taken + 6'd1;
        end else if (!suffix) begin
          if (!b) begin
            if (zeros < MAXZ) zeros <= zeros + 5'd1;
          end else begin
            suffix <= 1'b1;
            taken <= '0;
            acc <= '0;
          end
        end else begin
          acc <= acc_sh;
          taken <= taken + 6'd1;
        end
      end
    end
  end
endmodule

/* tb/sv/sps_parse_checker.sv */
`timescale 1ns / 100ps

// Watches both channels, runs a bit-serial SPS parser of its own on every
// accepted input beat and compares each result beat with the oldest expected one.
module sps_parse_checker #(
  parameter int MAX_GOLOMB_ZEROS = 31
) (
  input  logic  clk,
  input  logic  rst,
  sps_stream_if in_mon,
  sps_stream_if out_mon,
  output int    fails,
  output int    pending
);

  // parser state
  logic [5:0]  pos;
  int          zeros;
  logic [31:0] acc;
  int          nbits;
  bit          suffix;
  bit          is444;
  int          list_no;
  int          entry;
  logic [7:0]  last_scale;
  logic [7:0]  next_scale;
  logic [31:0] remaining;
  sps_pkg::sps_fields_t fields;

  sps_pkg::sps_fields_t headers_due[$];
  sps_pkg::sps_fields_t want;
  sps_pkg::sps_beat_t   beat;

  initial begin
    fails = 0;
    pending = 0;
  end

  task automatic report(string what, longint got, longint exp_v);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, exp_v);
    fails++;
  endtask

  function automatic int fixed_width(logic [5:0] p);
    case (p)
      sps_pkg::P_PROFILE, sps_pkg::P_CONSTRAINT, sps_pkg::P_LEVEL, sps_pkg::P_AR_IDC,
      sps_pkg::P_PRIMARIES, sps_pkg::P_TRC, sps_pkg::P_MATRIX: return 8;
      sps_pkg::P_SAR: return 32;
      sps_pkg::P_VIDEO_FORMAT: return 3;
      sps_pkg::P_SEP_PLANE, sps_pkg::P_BYPASS, sps_pkg::P_SCALING_FLAG,
      sps_pkg::P_LIST_FLAG, sps_pkg::P_DELTA_ZERO, sps_pkg::P_GAPS,
      sps_pkg::P_FRAME_MBS, sps_pkg::P_MBAFF, sps_pkg::P_DIRECT, sps_pkg::P_CROP_FLAG,
      sps_pkg::P_VUI_FLAG, sps_pkg::P_AR_FLAG, sps_pkg::P_OVERSCAN,
      sps_pkg::P_OVERSCAN_APPR, sps_pkg::P_SIG_TYPE, sps_pkg::P_FULL_RANGE,
      sps_pkg::P_COLOUR_FLAG: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [3:0] bit_depth(logic [31:0] v);
    return (v > 6) ? 4'd14 : 4'(v + 8);
  endfunction

  task automatic enter_elem(logic [5:0] p);
    pos = p;
    acc = '0;
    nbits = 0;
    zeros = 0;
    suffix = 0;
  endtask

  task automatic restart_parse();
    fields.profile_idc = 8'd0;
    fields.level_idc = 8'd0;
    fields.chroma_format = 2'd1;
    fields.luma_depth = 4'd8;
    fields.chroma_depth = 4'd8;
    fields.reference_frames = 5'd0;
    fields.is_interlaced = 1'b0;
    fields.aspect_present = 1'b0;
    fields.video_range = -2'sd1;
    fields.colour_primaries = 8'd2;
    fields.transfer_characteristics = 8'd2;
    fields.matrix_coefficients = 8'd2;
    list_no = 0;
    entry = 0;
    last_scale = 8'd8;
    next_scale = 8'd8;
    remaining = '0;
    is444 = 0;
    enter_elem(sps_pkg::P_PROFILE);
  endtask

  task automatic next_list();
    list_no++;
    if (list_no >= (is444 ? 12 : 8)) enter_elem(sps_pkg::P_LOG2_FRAME);
    else enter_elem(sps_pkg::P_LIST_FLAG);
  endtask

  // one syntax element completed with value v
  task automatic complete(logic [31:0] v);
    case (pos)
      sps_pkg::P_PROFILE: begin
        fields.profile_idc = v[7:0];
        enter_elem(sps_pkg::P_CONSTRAINT);
      end
      sps_pkg::P_CONSTRAINT: enter_elem(sps_pkg::P_LEVEL);
      sps_pkg::P_LEVEL: begin
        fields.level_idc = v[7:0];
        enter_elem(sps_pkg::P_SPS_ID);
      end
      sps_pkg::P_SPS_ID:
        enter_elem(fields.profile_idc >= sps_pkg::HIGH_PROFILE ? sps_pkg::P_CHROMA
                                                               : sps_pkg::P_LOG2_FRAME);
      sps_pkg::P_CHROMA: begin
        is444 = (v == 3);
        fields.chroma_format = (v > 3) ? 2'd3 : v[1:0];
        enter_elem(is444 ? sps_pkg::P_SEP_PLANE : sps_pkg::P_LUMA_DEPTH);
      end
      sps_pkg::P_SEP_PLANE: enter_elem(sps_pkg::P_LUMA_DEPTH);
      sps_pkg::P_LUMA_DEPTH: begin
        fields.luma_depth = bit_depth(v);
        enter_elem(sps_pkg::P_CHROMA_DEPTH);
      end
      sps_pkg::P_CHROMA_DEPTH: begin
        fields.chroma_depth = bit_depth(v);
        enter_elem(sps_pkg::P_BYPASS);
      end
      sps_pkg::P_BYPASS: enter_elem(sps_pkg::P_SCALING_FLAG);
      sps_pkg::P_SCALING_FLAG: begin
        list_no = 0;
        enter_elem(v[0] ? sps_pkg::P_LIST_FLAG : sps_pkg::P_LOG2_FRAME);
      end
      sps_pkg::P_LIST_FLAG: begin
        if (v[0]) begin
          last_scale = 8'd8;
          next_scale = 8'd8;
          entry = 0;
          enter_elem(sps_pkg::P_LIST_DELTA);
        end else begin
          next_list();
        end
      end
      sps_pkg::P_LIST_DELTA: begin
        // deltas wrap modulo 256; a zero next value ends the list
        if (v[0]) next_scale = last_scale + v[8:1] + 8'd1;
        else next_scale = last_scale - v[8:1];
        if (next_scale == 8'd0) begin
          next_list();
        end else begin
          last_scale = next_scale;
          entry++;
          if (entry >= (list_no < 6 ? 16 : 64)) next_list();
          else enter_elem(sps_pkg::P_LIST_DELTA);
        end
      end
      sps_pkg::P_LOG2_FRAME: enter_elem(sps_pkg::P_POC_TYPE);
      sps_pkg::P_POC_TYPE:
        enter_elem(v == 0 ? sps_pkg::P_POC_LSB
                   : (v == 1 ? sps_pkg::P_DELTA_ZERO : sps_pkg::P_REF_FRAMES));
      sps_pkg::P_POC_LSB: enter_elem(sps_pkg::P_REF_FRAMES);
      sps_pkg::P_DELTA_ZERO: enter_elem(sps_pkg::P_OFF_NONREF);
      sps_pkg::P_OFF_NONREF: enter_elem(sps_pkg::P_OFF_TB);
      sps_pkg::P_OFF_TB: enter_elem(sps_pkg::P_CYCLE_LEN);
      sps_pkg::P_CYCLE_LEN: begin
        remaining = v;
        enter_elem(v == 0 ? sps_pkg::P_REF_FRAMES : sps_pkg::P_CYCLE_OFF);
      end
      sps_pkg::P_CYCLE_OFF: begin
        remaining = remaining - 1;
        enter_elem(remaining == 0 ? sps_pkg::P_REF_FRAMES : sps_pkg::P_CYCLE_OFF);
      end
      sps_pkg::P_REF_FRAMES: begin
        fields.reference_frames = (v > 16) ? 5'd16 : v[4:0];
        enter_elem(sps_pkg::P_GAPS);
      end
      sps_pkg::P_GAPS: enter_elem(sps_pkg::P_MB_W);
      sps_pkg::P_MB_W: enter_elem(sps_pkg::P_MB_H);
      sps_pkg::P_MB_H: enter_elem(sps_pkg::P_FRAME_MBS);
      sps_pkg::P_FRAME_MBS: begin
        fields.is_interlaced = ~v[0];
        enter_elem(v[0] ? sps_pkg::P_DIRECT : sps_pkg::P_MBAFF);
      end
      sps_pkg::P_MBAFF: enter_elem(sps_pkg::P_DIRECT);
      sps_pkg::P_DIRECT: enter_elem(sps_pkg::P_CROP_FLAG);
      sps_pkg::P_CROP_FLAG: begin
        remaining = 32'd4;
        enter_elem(v[0] ? sps_pkg::P_CROP : sps_pkg::P_VUI_FLAG);
      end
      sps_pkg::P_CROP: begin
        remaining = remaining - 1;
        enter_elem(remaining == 0 ? sps_pkg::P_VUI_FLAG : sps_pkg::P_CROP);
      end
      sps_pkg::P_VUI_FLAG: enter_elem(v[0] ? sps_pkg::P_AR_FLAG : sps_pkg::P_DONE);
      sps_pkg::P_AR_FLAG: begin
        fields.aspect_present = v[0];
        enter_elem(v[0] ? sps_pkg::P_AR_IDC : sps_pkg::P_OVERSCAN);
      end
      sps_pkg::P_AR_IDC:
        enter_elem(v[7:0] == sps_pkg::AR_EXTENDED ? sps_pkg::P_SAR : sps_pkg::P_OVERSCAN);
      sps_pkg::P_SAR: enter_elem(sps_pkg::P_OVERSCAN);
      sps_pkg::P_OVERSCAN:
        enter_elem(v[0] ? sps_pkg::P_OVERSCAN_APPR : sps_pkg::P_SIG_TYPE);
      sps_pkg::P_OVERSCAN_APPR: enter_elem(sps_pkg::P_SIG_TYPE);
      sps_pkg::P_SIG_TYPE: enter_elem(v[0] ? sps_pkg::P_VIDEO_FORMAT : sps_pkg::P_DONE);
      sps_pkg::P_VIDEO_FORMAT: enter_elem(sps_pkg::P_FULL_RANGE);
      sps_pkg::P_FULL_RANGE: begin
        fields.video_range = {1'b0, v[0]};
        enter_elem(sps_pkg::P_COLOUR_FLAG);
      end
      sps_pkg::P_COLOUR_FLAG: enter_elem(v[0] ? sps_pkg::P_PRIMARIES : sps_pkg::P_DONE);
      sps_pkg::P_PRIMARIES: begin
        fields.colour_primaries = v[7:0];
        enter_elem(sps_pkg::P_TRC);
      end
      sps_pkg::P_TRC: begin
        fields.transfer_characteristics = v[7:0];
        enter_elem(sps_pkg::P_MATRIX);
      end
      sps_pkg::P_MATRIX: begin
        fields.matrix_coefficients = v[7:0];
        enter_elem(sps_pkg::P_DONE);
      end
      default: enter_elem(sps_pkg::P_DONE);
    endcase
  endtask

  task automatic walk_bit(bit b);
    int w;
    logic [63:0] code;
    if (pos >= sps_pkg::P_DONE) return;
    w = fixed_width(pos);
    if (w != 0) begin
      acc = {acc[30:0], b};
      nbits++;
      if (nbits >= w) complete(acc);
      return;
    end
    // Exp-Golomb prefix, saturating zero count
    if (!suffix) begin
      if (!b) begin
        if (zeros < MAX_GOLOMB_ZEROS) zeros++;
      end else if (zeros == 0) begin
        complete('0);
      end else begin
        suffix = 1;
        nbits = 0;
        acc = '0;
      end
      return;
    end
    acc = {acc[30:0], b};
    nbits++;
    if (nbits >= zeros) begin
      code = ((64'd1 << zeros) - 64'd1) + {32'd0, acc};
      complete(code[31:0]);
    end
  endtask

  task automatic compare_fields(sps_pkg::sps_fields_t got, sps_pkg::sps_fields_t exp_f);
    if (got.profile_idc !== exp_f.profile_idc)
      report("profile_idc", got.profile_idc, exp_f.profile_idc);
    if (got.level_idc !== exp_f.level_idc)
      report("level_idc", got.level_idc, exp_f.level_idc);
    if (got.chroma_format !== exp_f.chroma_format)
      report("chroma_format", got.chroma_format, exp_f.chroma_format);
    if (got.luma_depth !== exp_f.luma_depth)
      report("luma_depth", got.luma_depth, exp_f.luma_depth);
    if (got.chroma_depth !== exp_f.chroma_depth)
      report("chroma_depth", got.chroma_depth, exp_f.chroma_depth);
    if (got.reference_frames !== exp_f.reference_frames)
      report("reference_frames", got.reference_frames, exp_f.reference_frames);
    if (got.is_interlaced !== exp_f.is_interlaced)
      report("is_interlaced", got.is_interlaced, exp_f.is_interlaced);
    if (got.aspect_present !== exp_f.aspect_present)
      report("aspect_present", got.aspect_present, exp_f.aspect_present);
    if (got.video_range !== exp_f.video_range)
      report("video_range", got.video_range, exp_f.video_range);
    if (got.colour_primaries !== exp_f.colour_primaries)
      report("colour_primaries", got.colour_primaries, exp_f.colour_primaries);
    if (got.transfer_characteristics !== exp_f.transfer_characteristics)
      report("transfer_characteristics", got.transfer_characteristics,
             exp_f.transfer_characteristics);
    if (got.matrix_coefficients !== exp_f.matrix_coefficients)
      report("matrix_coefficients", got.matrix_coefficients, exp_f.matrix_coefficients);
  endtask

  initial restart_parse();

  // sample both channels at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_mon.valid && out_mon.ready) begin
        if (headers_due.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          want = headers_due.pop_front();
          compare_fields(sps_pkg::sps_fields_t'(out_mon.data), want);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        beat = sps_pkg::sps_beat_t'(in_mon.data);
        for (int k = 7; k >= 0; k--) walk_bit(beat.payload_byte[k]);
        if (beat.final_byte) begin
          headers_due.push_back(fields);
          restart_parse();
        end
      end
    end
    pending = headers_due.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 1250;
  localparam int MAX_ZEROS = 31;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   sent;
  int   quiet_cycles;
  int   send_idle_pct;
  int   recv_stall_pct;

  bit                 sps_bits[$];
  sps_pkg::sps_beat_t beats[$];

  sps_stream_if #(.W($bits(sps_pkg::sps_beat_t)))   in_if ();
  sps_stream_if #(.W($bits(sps_pkg::sps_fields_t))) out_if ();

  h264_sps_header_parser_core #(.MAX_GOLOMB_ZEROS(MAX_ZEROS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  sps_parse_checker #(.MAX_GOLOMB_ZEROS(MAX_ZEROS)) u_checker (
    .clk     (clk),
    .rst     (rst),
    .in_mon  (in_if),
    .out_mon (out_if),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent = 0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // valid stays up between beats; idle cycles and drain lower it
  task automatic send_beat(sps_pkg::sps_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_queued();
    while (beats.size() > 0) send_beat(beats.pop_front());
  endtask

  task automatic put_bits(logic [63:0] val, int n);
    for (int i = n - 1; i >= 0; i--) sps_bits.push_back(val[i]);
  endtask

  task automatic put_ue(longint unsigned v);
    logic [63:0] code;
    int len;
    code = v + 64'd1;
    len = 0;
    for (int i = 0; i < 64; i++) if (code[i]) len = i + 1;
    put_bits(64'd0, len - 1);
    put_bits(code, len);
  endtask

  // random code value, mostly small
  function automatic longint unsigned pick_ue(int hi);
    return ($urandom_range(9) == 0) ? 64'($urandom) : 64'($urandom_range(hi));
  endfunction

  // stop bit, byte packing, optional truncation or trailing junk
  task automatic pack_and_send(bit messy);
    sps_pkg::sps_beat_t b;
    int keep;
    sps_bits.push_back(1'b1);
    while (sps_bits.size() % 8 != 0) sps_bits.push_back(1'b0);
    while (sps_bits.size() > 0) begin
      for (int k = 7; k >= 0; k--) b.payload_byte[k] = sps_bits.pop_front();
      b.final_byte = 1'b0;
      beats.push_back(b);
    end
    if (messy && $urandom_range(9) == 0) begin
      keep = $urandom_range(beats.size(), 1);
      while (beats.size() > keep) void'(beats.pop_back());
    end else if (messy && $urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        b.payload_byte = 8'($urandom);
        beats.push_back(b);
      end
    end
    beats[beats.size() - 1].final_byte = 1'b1;
    send_queued();
  endtask

  // one SPS with random content, possibly truncated or with trailing junk; extreme forces the corners
  task automatic build_sps(bit extreme);
    int profile;
    longint unsigned chroma;
    int poc;
    int cycles;
    int entries;
    int v;
    logic [7:0] last_v;
    logic [7:0] next_v;
    bit vui;
    bit sig;
    case ($urandom_range(7))
      0: profile = 66;
      1: profile = 77;
      2: profile = 100;
      3: profile = 110;
      4: profile = 122;
      5: profile = 244;
      default: profile = $urandom_range(255);
    endcase
    if (extreme) profile = 244;
    put_bits(64'(profile), 8);
    put_bits(64'($urandom), 8);
    put_bits(extreme ? 64'd255 : 64'($urandom), 8);
    put_ue(pick_ue(31));
    if (profile >= 100) begin
      chroma = extreme ? 64'd7
               : (($urandom_range(5) == 0) ? pick_ue(8) : 64'($urandom_range(3)));
      put_ue(chroma);
      if (chroma == 3) put_bits(64'($urandom), 1);
      put_ue(extreme ? 64'd9 : pick_ue(8));
      put_ue(extreme ? 64'd0 : pick_ue(8));
      put_bits(64'($urandom), 1);
      if ($urandom_range(2) == 0 || extreme) begin
        put_bits(64'd1, 1);
        for (int l = 0; l < ((chroma == 3) ? 12 : 8); l++) begin
          put_bits(64'($urandom_range(1) | extreme), 1);
          if (sps_bits[sps_bits.size() - 1]) begin
            entries = (l < 6) ? 16 : 64;
            last_v = 8'd8;
            for (int e = 0; e < entries; e++) begin
              // occasionally end the list early with a zero next value
              v = ($urandom_range(19) == 0) ? 2 * int'(last_v) : int'($urandom_range(40));
              if (v[0]) next_v = last_v + 8'(v >> 1) + 8'd1;
              else next_v = last_v - 8'(v >> 1);
              put_ue(64'(v));
              if (next_v == 8'd0) break;
              last_v = next_v;
            end
          end
        end
      end else begin
        put_bits(64'd0, 1);
      end
    end
    put_ue(64'($urandom_range(12)));
    poc = $urandom_range(2);
    put_ue(($urandom_range(9) == 0) ? pick_ue(20) : 64'(poc));
    if (sps_bits.size() > 0) begin
      if (poc == 0) begin
        put_ue(64'($urandom_range(12)));
      end else if (poc == 1) begin
        put_bits(64'($urandom), 1);
        put_ue(pick_ue(50));
        put_ue(pick_ue(50));
        cycles = $urandom_range(4);
        put_ue(64'(cycles));
        repeat (cycles) put_ue(pick_ue(50));
      end
    end
    // long prefix: zeros beyond the limit are absorbed
    if (extreme) begin
      put_bits(64'd0, 40);
      put_bits(64'd1, 1);
      put_bits({$urandom, $urandom}, 31);
    end else begin
      put_ue(pick_ue(20));
    end
    put_bits(64'($urandom), 1);
    put_ue(pick_ue(120));
    put_ue(pick_ue(70));
    put_bits(64'($urandom), 1);
    if (!sps_bits[sps_bits.size() - 1]) put_bits(64'($urandom), 1);
    put_bits(64'($urandom), 1);
    put_bits(64'($urandom_range(1)), 1);
    if (sps_bits[sps_bits.size() - 1]) repeat (4) put_ue(pick_ue(20));
    vui = extreme || ($urandom_range(3) != 0);
    put_bits(64'(vui), 1);
    if (vui) begin
      put_bits(64'($urandom_range(1) | extreme), 1);
      if (sps_bits[sps_bits.size() - 1]) begin
        put_bits((extreme || $urandom_range(1)) ? 64'd255 : 64'(8'($urandom)), 8);
        if (sps_bits[sps_bits.size() - 1] && sps_bits[sps_bits.size() - 8])
          put_bits(64'($urandom), 32);
      end
      put_bits(64'($urandom_range(1)), 1);
      if (sps_bits[sps_bits.size() - 1]) put_bits(64'($urandom), 1);
      sig = extreme || $urandom_range(1);
      put_bits(64'(sig), 1);
      if (sig) begin
        put_bits(64'($urandom), 3);
        put_bits(64'($urandom), 1);
        put_bits(64'($urandom_range(1) | extreme), 1);
        if (sps_bits[sps_bits.size() - 1]) put_bits(64'($urandom), 24);
      end
    end
    pack_and_send(!extreme);
  endtask

  // sender quiet until every expected result has been checked
  task automatic drain();
    in_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
    wait (pending == 0);
    repeat (12) @(posedge clk);
  endtask

  // main sequence
  initial begin
    sps_pkg::sps_beat_t b;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: lone beats at the byte extremes, a two-beat header, then a corner-case header
    b.payload_byte = 8'hff; b.final_byte = 1'b1; beats.push_back(b);
    b.payload_byte = 8'h00; b.final_byte = 1'b1; beats.push_back(b);
    b.payload_byte = 8'h64; b.final_byte = 1'b0; beats.push_back(b);
    b.payload_byte = 8'hff; b.final_byte = 1'b1; beats.push_back(b);
    send_queued();
    build_sps(1'b1);
    drain();

    // random phases, each with its own idle pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      while (sent < ITEM_TARGET * (phase + 1) / 4) begin
        if ($urandom_range(9) == 0) begin
          // noise beats
          repeat ($urandom_range(6, 1)) begin
            b.payload_byte = 8'($urandom);
            b.final_byte = ($urandom_range(3) == 0);
            beats.push_back(b);
          end
          send_queued();
        end else begin
          build_sps(1'b0);
        end
      end
      drain();
    end

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sps_pkg.sv
rtl/sps_stream_if.sv
rtl/sps_front.sv
rtl/sps_back.sv
rtl/h264_sps_header_parser_core.sv
tb/sv/sps_parse_checker.sv
tb/sv/testbench.sv
